>>> hdl/pimu_pkg.sv
// Package for the priority inheritance mutex unit: opcodes, result codes,
// sequencer states and sizes. No dependencies.
package pimu_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned StatW = 2;

  // bank sizes; the stream field layout is built for these values
  localparam int unsigned NumMutexes = 16;
  localparam int unsigned NumTasks   = 32;
  localparam int unsigned PrioBits   = 6;
  localparam int unsigned NestBits   = 8;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_UNLOCK  = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_FAILED   = 2'd1,
    ST_TIMEDOUT = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_SCANW,
    S_SHIFT,
    S_SHIFTW,
    S_FINISH,
    S_OUT1,
    S_OUT2
  } seq_state_e;

  localparam int unsigned CfgCeiling = 0;

endpackage

>>> hdl/pimu_queue_ram.sv
// Wait-queue storage for all mutexes: one write port, one registered read
// port. Depends on nothing but its parameters.
module pimu_queue_ram #(
  parameter int unsigned AW = 9,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/priority_inheritance_mutex_unit.sv
// Top level of the priority inheritance mutex unit: sequencer, per-mutex
// registers and result output. Depends on pimu_pkg and pimu_queue_ram.
//
// Channel  | Dir | Fields (lsb first)
// s_axis   | in  | tdata: opcode, mutex_id, task_id, task_priority, may_wait
// m_axis   | out | tdata: target_task, status, new_priority; tuser: kind; tlast
// apb      | in  | priority_ceiling at address 0
//
// A transaction takes the accept state in idle, a lookup state and an output
// state per result. Queue work adds an address and a data state per slot
// scanned and per slot moved, a finish state, and one more state when a timeout
// recomputes the owner priority. s_axis_tready is high only in idle. A stalled
// m_axis holds the sequencer. After reset all mutexes are free, queues empty.
module priority_inheritance_mutex_unit
  import pimu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // opcode[1:0], mutex_id[5:2], task_id[10:6], task_priority[16:11], may_wait[17]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_task[4:0], status[6:5], new_priority[12:7]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MW  = (NumMutexes > 1) ? $clog2(NumMutexes) : 1;
  localparam int unsigned TW  = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int unsigned CW  = $clog2(NumTasks + 1);
  localparam int unsigned PW  = PrioBits;
  localparam int unsigned AW  = MW + TW;
  localparam int unsigned EW  = TW + PW;
  localparam logic [NestBits-1:0] NestMax = '1;

  // ---- configuration ----
  logic [5:0] ceil_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(CfgCeiling)) ? {26'd0, ceil_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'(CfgCeiling)) begin
      ceil_q <= pwdata[5:0];
    end
  end

  // ---- per-mutex state ----
  logic [TW-1:0]       owner_q [NumMutexes];
  logic [NestBits-1:0] nest_q  [NumMutexes];
  logic [PW-1:0]       cur_q   [NumMutexes];
  logic [PW-1:0]       orig_q  [NumMutexes];
  logic [CW-1:0]       cnt_q   [NumMutexes];

  // ---- request registers ----
  logic [1:0]    op_q;
  logic [MW-1:0] mid_q;
  logic [TW-1:0] tsk_q;
  logic [PW-1:0] pri_q;
  logic          wait_q;

  seq_state_e st_q, st_d;
  logic [CW-1:0] pos_q, pos_d;   // scan / shift index
  logic [CW-1:0] i_q, i_d;
  logic [EW-1:0] head_q, head_d;
  logic          hit_q, hit_d;

  // result slots
  logic          r1v_q, r1v_d, r2v_q, r2v_d;
  logic          r1k_q, r1k_d, r2k_q, r2k_d;
  logic [TW-1:0] r1t_q, r1t_d, r2t_q, r2t_d;
  logic [1:0]    r1s_q, r1s_d, r2s_q, r2s_d;
  logic [PW-1:0] r1p_q, r1p_d, r2p_q, r2p_d;

  // queue memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  pimu_queue_ram #(.AW(AW), .DW(EW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [TW-1:0] rd_task;
  logic [PW-1:0] rd_prio;
  assign rd_task = rdata[EW-1:PW];
  assign rd_prio = rdata[PW-1:0];

  logic [TW-1:0]       own;
  logic [NestBits-1:0] nst;
  logic [PW-1:0]       cur, orig;
  logic [CW-1:0]       cnt;
  assign own  = owner_q[mid_q];
  assign nst  = nest_q[mid_q];
  assign cur  = cur_q[mid_q];
  assign orig = orig_q[mid_q];
  assign cnt  = cnt_q[mid_q];

  function automatic logic [PW-1:0] clim(input logic [PW-1:0] p, input logic [5:0] c);
    logic [PW-1:0] cc;
    cc = PW'(c & 6'((1 << PW) - 1));
    return (p > cc) ? p : cc;
  endfunction

  function automatic logic [AW-1:0] qa(input logic [MW-1:0] m, input logic [CW-1:0] i);
    return {m, i[TW-1:0]};
  endfunction

  // state write strobes
  logic                wr_m;
  logic [TW-1:0]       w_own;
  logic [NestBits-1:0] w_nst;
  logic [PW-1:0]       w_cur, w_orig;
  logic [CW-1:0]       w_cnt;

  logic [PW-1:0] np, bst;

  always_comb begin
    st_d = st_q; pos_d = pos_q; i_d = i_q; head_d = head_q; hit_d = hit_q;
    r1v_d = r1v_q; r1k_d = r1k_q; r1t_d = r1t_q; r1s_d = r1s_q; r1p_d = r1p_q;
    r2v_d = r2v_q; r2k_d = r2k_q; r2t_d = r2t_q; r2s_d = r2s_q; r2p_d = r2p_q;
    we = 1'b0; waddr = qa(mid_q, i_q); wdata = head_q; raddr = qa(mid_q, pos_q);
    wr_m = 1'b0; w_own = own; w_nst = nst; w_cur = cur; w_orig = orig; w_cnt = cnt;
    np = '0; bst = '0;
    s_axis_tready = (st_q == S_IDLE);
    case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          st_d = S_LOOK;
        end
      end
      S_LOOK: begin
        r1v_d = 1'b0; r2v_d = 1'b0; r1s_d = '0; r1p_d = '0; r2s_d = '0; r2p_d = '0;
        pos_d = '0; hit_d = 1'b0;
        st_d = S_IDLE;
        if (32'(mid_q) < NumMutexes && op_q != OP_NONE) begin
          case (opcode_e'(op_q))
            OP_LOCK: begin
              if (nst == '0 || own == tsk_q) begin
                r1v_d = 1'b1; r1k_d = 1'b0; r1t_d = tsk_q;
                st_d = S_OUT1;
                if (nst == NestMax) begin
                  r1s_d = ST_FAILED;
                end else begin
                  r1s_d = ST_GRANTED;
                  wr_m = 1'b1; w_own = tsk_q; w_cur = pri_q;
                  if (nst == '0) w_orig = pri_q;
                  w_nst = nst + 1'b1;
                end
              end else if (!wait_q || 32'(cnt) >= NumTasks) begin
                r1v_d = 1'b1; r1k_d = 1'b0; r1t_d = tsk_q; r1s_d = ST_FAILED;
                st_d = S_OUT1;
              end else begin
                st_d = (cnt == '0) ? S_FINISH : S_SCAN;
              end
            end
            OP_UNLOCK: begin
              if (own == tsk_q && nst != '0) begin
                wr_m = 1'b1; w_nst = nst - 1'b1;
                if (nst == NestBits'(1)) begin
                  st_d = (cnt == '0) ? S_FINISH : S_SCAN;
                end
              end
            end
            default: begin
              st_d = (cnt == '0) ? S_IDLE : S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        // read issued at pos_q
        st_d = S_SCANW;
      end
      S_SCANW: begin
        if (op_q == OP_LOCK) begin
          if (rd_prio > pri_q) begin
            // insert at pos: shift tail up from cnt
            i_d = cnt; st_d = S_SHIFT;
          end else if (pos_q + 1'b1 == cnt) begin
            pos_d = cnt; st_d = S_FINISH;
          end else begin
            pos_d = pos_q + 1'b1; st_d = S_SCAN;
          end
        end else if (op_q == OP_UNLOCK) begin
          head_d = rdata; i_d = '0; hit_d = 1'b1;
          st_d = (cnt == CW'(1)) ? S_FINISH : S_SHIFT;
          pos_d = CW'(1);
        end else begin
          if (rd_task == tsk_q) begin
            hit_d = 1'b1; i_d = pos_q;
            pos_d = pos_q + 1'b1;
            st_d = (pos_q + 1'b1 == cnt) ? S_FINISH : S_SHIFT;
          end else if (pos_q + 1'b1 == cnt) begin
            st_d = S_IDLE;
          end else begin
            pos_d = pos_q + 1'b1; st_d = S_SCAN;
          end
        end
      end
      S_SHIFT: begin
        // lock: read i-1 to write at i; others: read pos to write at i
        if (op_q == OP_LOCK) raddr = qa(mid_q, i_q - 1'b1);
        st_d = S_SHIFTW;
      end
      S_SHIFTW: begin
        we = 1'b1; wdata = rdata; waddr = qa(mid_q, i_q);
        if (op_q == OP_LOCK) begin
          i_d = i_q - 1'b1;
          st_d = (i_q - 1'b1 == pos_q) ? S_FINISH : S_SHIFT;
        end else begin
          i_d = i_q + 1'b1; pos_d = pos_q + 1'b1;
          st_d = (pos_q + 1'b1 == cnt) ? S_FINISH : S_SHIFT;
        end
      end
      S_FINISH: begin
        st_d = S_IDLE;
        wr_m = 1'b1;
        case (opcode_e'(op_q))
          OP_LOCK: begin
            we = 1'b1; waddr = qa(mid_q, pos_q); wdata = {tsk_q, pri_q};
            w_cnt = cnt + 1'b1;
            bst = clim(pri_q, ceil_q);
            if (pri_q < cur && bst < cur) begin
              r1v_d = 1'b1; r1k_d = 1'b1; r1t_d = own; r1p_d = bst;
              w_cur = bst; st_d = S_OUT1;
            end
          end
          OP_UNLOCK: begin
            if (cur != orig) begin
              r1v_d = 1'b1; r1k_d = 1'b1; r1t_d = own; r1p_d = orig;
              st_d = S_OUT1;
            end
            if (hit_q) begin
              w_cnt = cnt - 1'b1;
              w_own = head_q[EW-1:PW]; w_nst = NestBits'(1);
              w_cur = head_q[PW-1:0]; w_orig = head_q[PW-1:0];
              if (cur != orig) begin
                r2v_d = 1'b1; r2k_d = 1'b0; r2t_d = head_q[EW-1:PW];
              end else begin
                r1v_d = 1'b1; r1k_d = 1'b0; r1t_d = head_q[EW-1:PW];
              end
              st_d = S_OUT1;
            end else begin
              w_own = '0;
            end
          end
          default: begin
            w_cnt = cnt - 1'b1;
            r1v_d = 1'b1; r1k_d = 1'b0; r1t_d = tsk_q; r1s_d = ST_TIMEDOUT;
            st_d = S_OUT1;
            if (nst != '0) begin
              // recompute owner priority, head read is pending
              st_d = S_OUT2;
            end
          end
        endcase
      end
      S_OUT2: begin
        // timeout with owner: head entry (slot 0) in rdata if cnt>0
        np = orig;
        if (cnt != '0) begin
          if (rd_prio < np) np = rd_prio;
          np = clim(np, ceil_q);
        end
        if (cur != np) begin
          r2v_d = 1'b1; r2k_d = 1'b0; r2t_d = r1t_q; r2s_d = ST_TIMEDOUT;
          r1k_d = 1'b1; r1t_d = own; r1s_d = '0; r1p_d = np;
          wr_m = 1'b1; w_cur = np;
        end
        st_d = S_OUT1;
      end
      S_OUT1: begin
        if (m_axis_tready) begin
          r1v_d = r2v_q; r1k_d = r2k_q; r1t_d = r2t_q; r1s_d = r2s_q; r1p_d = r2p_q;
          r2v_d = 1'b0;
          st_d = r2v_q ? S_OUT1 : S_IDLE;
          if (!r1v_q) st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_FINISH && op_q == OP_TIMEOUT) raddr = qa(mid_q, '0);
  end

  assign m_axis_tvalid = (st_q == S_OUT1) && r1v_q;
  assign m_axis_tlast  = !r2v_q;
  assign m_axis_tuser  = r1k_q;
  assign m_axis_tdata  = 16'({r1p_q, r1s_q, r1t_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      r1v_q <= 1'b0;
      r2v_q <= 1'b0;
      for (int k = 0; k < NumMutexes; k++) begin
        owner_q[k] <= '0; nest_q[k] <= '0; cur_q[k] <= '0;
        orig_q[k] <= '0; cnt_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      r1v_q <= r1v_d;
      r2v_q <= r2v_d;
      if (wr_m) begin
        owner_q[mid_q] <= w_own; nest_q[mid_q] <= w_nst; cur_q[mid_q] <= w_cur;
        orig_q[mid_q] <= w_orig; cnt_q[mid_q] <= w_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && s_axis_tvalid) begin
      op_q   <= s_axis_tdata[1:0];
      mid_q  <= MW'(s_axis_tdata[5:2]);
      tsk_q  <= TW'(s_axis_tdata[10:6]);
      pri_q  <= PW'(s_axis_tdata[16:11]);
      wait_q <= s_axis_tdata[17];
    end
    pos_q <= pos_d; i_q <= i_d; head_q <= head_d; hit_q <= hit_d;
    r1k_q <= r1k_d; r1t_q <= r1t_d; r1s_q <= r1s_d; r1p_q <= r1p_d;
    r2k_q <= r2k_d; r2t_q <= r2t_d; r2s_q <= r2s_d; r2p_q <= r2p_d;
  end

endmodule

>>> hdl/pimu_checker.sv
// Port-level checker for the priority inheritance mutex unit, bound to the
// top level. Depends only on the top-level ports.
module pimu_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast,
  input logic [15:0] m_axis_tdata
);

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after accept");

  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[6:5] == 2'd0)
    else $error("priority command carries status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  // a result that is not the last one is followed right away by the next
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second result missing");

endmodule

bind priority_inheritance_mutex_unit pimu_port_checker u_pimu_checker (.*);
